// ----- sv/ced_pkg.sv -----
// ============================================================================
// ced_pkg: shared types and constants for the counter decay pipeline
// Payload structs for both channels, inter-stage records and the factor table.
// ============================================================================
package ced_pkg;

    localparam int          TABLE_LOG      = 5;
    localparam int          WHOLE_W        = 5;
    localparam logic [31:0] BACKWARD_LIMIT = 32'hFFFF_FC00;

    typedef struct packed {
        logic [31:0] stamp_now;
        logic [31:0] stamp_prev;
        logic [31:0] load_in;
    } in_t;

    typedef struct packed {
        logic [31:0] load_out;
        logic [31:0] time_out;
        logic        time_advanced;
    } out_t;

    // Record after tick extraction.
    typedef struct packed {
        logic [31:0]          load;
        logic [31:0]          stamp_now;
        logic [31:0]          stamp_prev;
        logic                 advanced;
        logic                 clear;
        logic                 unity;
        logic [WHOLE_W-1:0]   whole;
        logic [TABLE_LOG-1:0] idx;
    } tick_t;

    // Record after the fraction multiply.
    typedef struct packed {
        logic [63:0]        product;
        logic [31:0]        load;
        logic [31:0]        stamp_now;
        logic [31:0]        stamp_prev;
        logic               advanced;
        logic               clear;
        logic               unity;
        logic [WHOLE_W-1:0] whole;
    } prod_t;

    // round(2^32 * 0.5^(k/32)); entry 0 would be 2^32, is stored as 0 and its product is bypassed.
    function automatic logic [31:0] decay_factor(input logic [TABLE_LOG-1:0] k);
        logic [31:0] f;
        begin
            unique case (k)
                5'd0:  f = 32'd0;
                5'd1:  f = 32'd4202935003;
                5'd2:  f = 32'd4112874773;
                5'd3:  f = 32'd4024744348;
                5'd4:  f = 32'd3938502376;
                5'd5:  f = 32'd3854108391;
                5'd6:  f = 32'd3771522796;
                5'd7:  f = 32'd3690706840;
                5'd8:  f = 32'd3611622603;
                5'd9:  f = 32'd3534232978;
                5'd10: f = 32'd3458501653;
                5'd11: f = 32'd3384393094;
                5'd12: f = 32'd3311872529;
                5'd13: f = 32'd3240905930;
                5'd14: f = 32'd3171459999;
                5'd15: f = 32'd3103502151;
                5'd16: f = 32'd3037000500;
                5'd17: f = 32'd2971923842;
                5'd18: f = 32'd2908241642;
                5'd19: f = 32'd2845924021;
                5'd20: f = 32'd2784941738;
                5'd21: f = 32'd2725266179;
                5'd22: f = 32'd2666869345;
                5'd23: f = 32'd2609723834;
                5'd24: f = 32'd2553802834;
                5'd25: f = 32'd2499080105;
                5'd26: f = 32'd2445529972;
                5'd27: f = 32'd2393127307;
                5'd28: f = 32'd2341847524;
                5'd29: f = 32'd2291666561;
                5'd30: f = 32'd2242560872;
                5'd31: f = 32'd2194507417;
            endcase
            return f;
        end
    endfunction

endpackage

// ----- sv/ced_tick.sv -----
// ============================================================================
// ced_tick: tick extraction stage
// Turns the elapsed time into ticks, whole half-lives and a table index.
// ============================================================================
module ced_tick #(
    parameter int HALVING_LOG  = 5,
    parameter int COUNTER_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [4:0]                    tick_length_log,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ced_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ced_pkg::tick_t                out_data
);
    import ced_pkg::*;

    localparam logic [31:0] LOAD_MASK = 32'hFFFF_FFFF >> (32 - COUNTER_BITS);
    localparam logic [31:0] FRAC_MASK = (32'd1 << HALVING_LOG) - 32'd1;
    localparam int          UP        = (HALVING_LOG <= TABLE_LOG) ?
                                        (TABLE_LOG - HALVING_LOG) : 0;
    localparam int          DOWN      = (HALVING_LOG > TABLE_LOG) ?
                                        (HALVING_LOG - TABLE_LOG) : 0;

    logic        valid_reg;
    tick_t       data_reg;
    tick_t       data_next;
    logic [31:0] ticks;
    logic [31:0] whole_full;
    logic [31:0] frac_scaled;
    logic        advanced;

    always_comb begin
        ticks       = (in_data.stamp_now - in_data.stamp_prev) >> tick_length_log;
        // Huge tick counts mean the clock ran backwards: treat as no ticks.
        advanced    = (ticks != 32'd0) && (ticks <= BACKWARD_LIMIT);
        whole_full  = ticks >> HALVING_LOG;
        frac_scaled = ((ticks & FRAC_MASK) << UP) >> DOWN;

        data_next.load       = in_data.load_in & LOAD_MASK;
        data_next.stamp_now  = in_data.stamp_now;
        data_next.stamp_prev = in_data.stamp_prev;
        data_next.advanced   = advanced;
        data_next.clear      = advanced && (whole_full >= 32'(COUNTER_BITS));
        data_next.idx        = frac_scaled[TABLE_LOG-1:0];
        data_next.unity      = (frac_scaled[TABLE_LOG-1:0] == '0);
        data_next.whole      = whole_full[WHOLE_W-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- sv/ced_mult.sv -----
// ============================================================================
// ced_mult: fraction multiply stage
// Multiplies the counter by the table factor for the fractional half-lives.
// ============================================================================
module ced_mult (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ced_pkg::tick_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ced_pkg::prod_t  out_data
);
    import ced_pkg::*;

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    always_comb begin
        data_next.product    = 64'(in_data.load) * 64'(decay_factor(in_data.idx));
        data_next.load       = in_data.load;
        data_next.stamp_now  = in_data.stamp_now;
        data_next.stamp_prev = in_data.stamp_prev;
        data_next.advanced   = in_data.advanced;
        data_next.clear      = in_data.clear;
        data_next.unity      = in_data.unity;
        data_next.whole      = in_data.whole;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- sv/ced_scale.sv -----
// ============================================================================
// ced_scale: rounding and half-life shift stage
// Rounds and shifts by whole half-lives, clears or passes the load; holds it.
// ============================================================================
module ced_scale (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ced_pkg::prod_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ced_pkg::out_t   out_data
);
    import ced_pkg::*;

    logic        valid_reg;
    out_t        data_reg;
    out_t        data_next;
    logic [31:0] rounded;
    logic [31:0] mantissa;

    always_comb begin
        // Round at bit 31 and keep the top word; cannot carry out of 32 bits.
        rounded  = in_data.product[63:32] + {31'd0, in_data.product[31]};
        mantissa = in_data.unity ? in_data.load : rounded;

        data_next.time_advanced = in_data.advanced;
        data_next.time_out      = in_data.advanced ? in_data.stamp_now : in_data.stamp_prev;
        if (!in_data.advanced) begin
            data_next.load_out = in_data.load;
        end else if (in_data.clear) begin
            data_next.load_out = 32'd0;
        end else begin
            data_next.load_out = mantissa >> in_data.whole;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- sv/counter_exponential_decay.sv -----
// ============================================================================
// counter_exponential_decay: streaming decay of rate-limiter load counters
// Three-stage pipeline: tick extraction, fraction multiply, round and shift.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one counter: time now, time of last decay
//   and the counter value. m_valid/m_ready/m_data return the decayed value,
//   the new last-update time and a flag telling whether time advanced.
//   cfg_wr_en/cfg_wr_data write tick_length_log; write it only while idle.
//   A counter taken on s_data passes the tick, multiply and scale registers
//   in that order before it is presented on m_data. Throughput: one counter
//   per cycle while m_ready is high; the 32x32 multiply sits in a single stage.
//   Every stage holds its own valid bit; a stalled receiver backs up the
//   stages one by one, and s_ready drops only when all three are full.
//   Nothing is lost or repeated across a stall.
//   Reset clears all valid bits and sets tick_length_log to 0.
// ============================================================================
module counter_exponential_decay #(
    parameter int HALVING_LOG  = 5,
    parameter int COUNTER_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [4:0]     cfg_wr_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  ced_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ced_pkg::out_t  m_data
);
    import ced_pkg::*;

    logic [4:0] tick_length_log_reg;

    logic  tick_valid;
    logic  tick_ready;
    tick_t tick_data;
    logic  prod_valid;
    logic  prod_ready;
    prod_t prod_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_length_log_reg <= 5'd0;
        end else if (cfg_wr_en) begin
            tick_length_log_reg <= cfg_wr_data;
        end
    end

    ced_tick #(
        .HALVING_LOG  (HALVING_LOG),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_tick (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick_length_log (tick_length_log_reg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_data         (s_data),
        .out_valid       (tick_valid),
        .out_ready       (tick_ready),
        .out_data        (tick_data)
    );

    ced_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tick_valid),
        .in_ready  (tick_ready),
        .in_data   (tick_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    ced_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef SYNTH
    // Backpressure reaches the input only when every stage is occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (tick_valid && prod_valid && m_valid && !m_ready))
        else $error("input stalled while a stage was free");

    // A cleared counter must come from an item whose time advanced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_valid && tick_data.clear) |-> tick_data.advanced)
        else $error("clear set without time advance");

    // The bypassed factor must match a zero table index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_valid |-> (tick_data.unity == (tick_data.idx == '0)))
        else $error("unity flag disagrees with table index");

    // An item waiting in the multiply stage moves on once the output frees up.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_valid && prod_ready) |=> m_valid)
        else $error("multiply result lost on its way to the output");
`endif

endmodule
